FILE: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define RDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rdq_pkg.sv
// types and codes for the reversible deque
// no dependencies; imported by the cell, the top level and the checker
package rdq_pkg;

    // operation codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_PEEK_FRONT = 3'd3,
        KIND_REVERSE    = 3'd4
    } op_kind_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_ROTATE
    } ctl_state_t;

    // one stored record
    typedef struct packed {
        logic signed [31:0] id;
        logic [63:0]        data;
    } rec_t;

    // command transfer
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] record_id;
        logic [63:0]        record_data;
    } cmd_t;

    // result transfer
    typedef struct packed {
        logic               ok;
        logic signed [31:0] front_id;
        logic [63:0]        front_data;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               is_full;
    } res_t;

    // per-cycle command broadcast to the cell row
    typedef struct packed {
        logic shift_up;    // cell i takes cell i-1
        logic shift_down;  // cell i takes cell i+1
        logic wr_en;       // cell at wr_idx loads the new record
    } cell_ctl_t;

endpackage

FILE: sv/rdq_cell.sv
// one slot of the rotating record ring
// depends on rdq_pkg for the record and control types
module rdq_cell
    import rdq_pkg::*;
#(
    parameter int IW  = 4,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  cell_ctl_t     ctl,
    input  logic [IW-1:0] wr_idx,
    input  rec_t          wr_rec,
    input  rec_t          lo_rec,
    input  rec_t          hi_rec,
    output rec_t          rec
);

    rec_t rec_reg;
    rec_t rec_next;
    logic hit;

    // load beats a shift, a shift beats hold
    assign hit = ctl.wr_en && (wr_idx == IW'(IDX));

    always_comb
    begin
        if (hit)
        begin
            rec_next = wr_rec;
        end
        else if (ctl.shift_up)
        begin
            rec_next = lo_rec;
        end
        else if (ctl.shift_down)
        begin
            rec_next = hi_rec;
        end
        else
        begin
            rec_next = rec_reg;
        end
    end

    // record storage, contents undefined until written
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

FILE: sv/reversible_deque.sv
// reversible deque: push back, push front, pop, peek: result in the cycle after the transfer,
// a new command may follow in the very next cycle (one item per cycle)
// reverse on n records: n-1 rotation steps of the cell row, one per cycle, busy high,
// result in the cycle after the last step; n below 2 behaves like the other commands
// async reset clears count, direction and controller; record cells are not cleared
// depends on rdq_pkg and rdq_cell
module reversible_deque
    import rdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output res_t result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    ctl_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic          rev_reg, rev_next;
    logic          done_reg, done_next;
    res_t          res_reg, res_next;

    cell_ctl_t     ctl;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] back_idx;
    rec_t          new_rec;
    rec_t          cell_rec [DEPTH];
    logic          is_full_now;
    logic          is_empty_now;

    assign new_rec.id   = cmd.record_id;
    assign new_rec.data = cmd.record_data;

    assign is_full_now  = (count_reg == DEPTH_C);
    assign is_empty_now = (count_reg == '0);

    // slot just past the back record, walking in the current direction
    always_comb
    begin
        if (!rev_reg)
        begin
            back_idx = count_reg[IW-1:0];
        end
        else if (is_empty_now)
        begin
            back_idx = '0;
        end
        else
        begin
            back_idx = IW'(DEPTH_C - count_reg);
        end
    end

    // row of cells, front record in cell 0 whenever the controller is idle
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int LO = (i + DEPTH - 1) % DEPTH;
        localparam int HI = (i + 1) % DEPTH;
        rdq_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .wr_idx (wr_idx),
            .wr_rec (new_rec),
            .lo_rec (cell_rec[LO]),
            .hi_rec (cell_rec[HI]),
            .rec    (cell_rec[i])
        );
    end

    // controller: next state, cell commands and result
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        steps_next = steps_reg;
        rev_next   = rev_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ctl        = '0;
        wr_idx     = back_idx;

        res_next.ok         = 1'b0;
        res_next.front_id   = '0;
        res_next.front_data = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    case (cmd.kind)
                        KIND_PUSH_BACK:
                        begin
                            if (!is_full_now)
                            begin
                                ctl.wr_en   = 1'b1;
                                count_next  = count_reg + ONE_C;
                                res_next.ok = 1'b1;
                            end
                        end
                        KIND_PUSH_FRONT:
                        begin
                            if (!is_full_now)
                            begin
                                // open a slot at cell 0 by stepping away from the front
                                ctl.wr_en      = 1'b1;
                                ctl.shift_up   = !rev_reg;
                                ctl.shift_down = rev_reg;
                                wr_idx         = '0;
                                count_next     = count_reg - '0 + ONE_C;
                                res_next.ok    = 1'b1;
                            end
                        end
                        KIND_POP_FRONT:
                        begin
                            if (!is_empty_now)
                            begin
                                // bring the second record into cell 0
                                ctl.shift_down      = !rev_reg;
                                ctl.shift_up        = rev_reg;
                                count_next          = count_reg - ONE_C;
                                res_next.ok         = 1'b1;
                                res_next.front_id   = cell_rec[0].id;
                                res_next.front_data = cell_rec[0].data;
                            end
                        end
                        KIND_PEEK_FRONT:
                        begin
                            if (!is_empty_now)
                            begin
                                res_next.ok         = 1'b1;
                                res_next.front_id   = cell_rec[0].id;
                                res_next.front_data = cell_rec[0].data;
                            end
                        end
                        KIND_REVERSE:
                        begin
                            res_next.ok = 1'b1;
                            if (count_reg > ONE_C)
                            begin
                                // back record must rotate round to cell 0 first
                                state_next = ST_ROTATE;
                                steps_next = count_reg - ONE_C;
                                done_next  = 1'b0;
                            end
                            else if (!is_empty_now)
                            begin
                                rev_next = !rev_reg;
                            end
                        end
                        default:
                        begin
                            res_next.ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_ROTATE:
            begin
                // one step in the pop direction per cycle
                ctl.shift_down = !rev_reg;
                ctl.shift_up   = rev_reg;
                steps_next     = steps_reg - ONE_C;
                if (steps_reg == ONE_C)
                begin
                    rev_next    = !rev_reg;
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    res_next.ok = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.entry_count = 5'(count_next);
        res_next.is_empty    = (count_next == '0);
        res_next.is_full     = (count_next == DEPTH_C);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            steps_reg <= '0;
            rev_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            steps_reg <= steps_next;
            rev_reg   <= rev_next;
            done_reg  <= done_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = (state_reg == ST_ROTATE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: sv/rdq_checker.sv
// port-level checks for the reversible deque, bound to the top level
// depends on rdq_pkg and assert_macros.svh
`include "assert_macros.svh"

module rdq_checker
    import rdq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cmd_t cmd,
    input logic done,
    input res_t result
);

    logic quick_cmd;
    logic front_zero;
    logic empty_flags_ok;

    // command transfer that is not a reverse
    assign quick_cmd = start && !busy && (cmd.kind != KIND_REVERSE);

    // front fields both clear
    assign front_zero = (result.front_id == '0) && (result.front_data == '0);

    // empty implies not full and a zero count
    assign empty_flags_ok = !result.is_full && (result.entry_count == '0);

    // any command but reverse answers in the next cycle
    `RDQ_ASSERT(a_quick_answer, quick_cmd |=> done, "command without result")

    // a result never shows while the ring is rotating
    `RDQ_ASSERT(a_done_not_busy, done |-> !busy, "result during rotation")

    // a refused operation reports no front record
    `RDQ_ASSERT(a_refused_zero, (done && !result.ok) |-> front_zero, "front fields on refusal")

    // empty and full exclude each other, empty means zero count
    `RDQ_ASSERT(a_flags, (done && result.is_empty) |-> empty_flags_ok, "inconsistent flags")

    // no result strobe in the cycle after reset is seen
    `RDQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !done, "result during reset")

endmodule

bind reversible_deque rdq_checker u_rdq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

FILE: test/tb_reversible_deque.sv
// self-checking testbench for the reversible deque: directed corner cases, then random traffic
// keeps its own ring model of the queue and compares every result against it
// depends on rdq_pkg and the reversible_deque top level
module tb_reversible_deque;
    import rdq_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int DRAIN_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cmd_t cmd = '0;
    logic done;
    res_t result;

    // ring model of the queue contents
    logic signed [31:0] ring_ids [DEPTH];
    logic [63:0] ring_data [DEPTH];
    int ring_head = 0;
    int held = 0;
    logic flipped = 1'b0;

    res_t replies_due [$];
    int fail_count = 0;
    int cmds_sent = 0;
    int results_checked = 0;
    int refused_pushes = 0;
    int reverses_done = 0;
    bit no_gaps = 1'b0;

    reversible_deque #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one line per mismatch, printing capped
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
                     results_checked);
    endtask

    // physical slot of the record at logical position pos from the front
    function automatic int ring_slot(int pos);
        if (!flipped)
            return (ring_head + pos) % DEPTH;
        return (ring_head + DEPTH - (pos % DEPTH)) % DEPTH;
    endfunction

    // apply one command to the ring model and return the result it must give
    function automatic res_t predict_deque_op(cmd_t c);
        res_t r;
        int slot;
        r = '0;
        case (c.kind)
            KIND_PUSH_BACK:
            begin
                if (held < DEPTH)
                begin
                    slot = ring_slot(held);
                    ring_ids[slot] = c.record_id;
                    ring_data[slot] = c.record_data;
                    held++;
                    r.ok = 1'b1;
                end
                else
                    refused_pushes++;
            end
            KIND_PUSH_FRONT:
            begin
                if (held < DEPTH)
                begin
                    ring_head = flipped ? (ring_head + 1) % DEPTH
                                        : (ring_head + DEPTH - 1) % DEPTH;
                    ring_ids[ring_head] = c.record_id;
                    ring_data[ring_head] = c.record_data;
                    held++;
                    r.ok = 1'b1;
                end
                else
                    refused_pushes++;
            end
            KIND_POP_FRONT, KIND_PEEK_FRONT:
            begin
                if (held > 0)
                begin
                    r.front_id = ring_ids[ring_head];
                    r.front_data = ring_data[ring_head];
                    if (c.kind == KIND_POP_FRONT)
                    begin
                        ring_head = flipped ? (ring_head + DEPTH - 1) % DEPTH
                                            : (ring_head + 1) % DEPTH;
                        held--;
                    end
                    r.ok = 1'b1;
                end
            end
            KIND_REVERSE:
            begin
                if (held > 0)
                begin
                    ring_head = ring_slot(held - 1);
                    flipped = ~flipped;
                end
                reverses_done++;
                r.ok = 1'b1;
            end
            default:
            begin
                // spare codes leave the queue alone
            end
        endcase
        r.entry_count = held[4:0];
        r.is_empty = (held == 0);
        r.is_full = (held >= DEPTH);
        return r;
    endfunction

    // idle gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic signed [31:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'sh8000_0000;
        if (r < 10)
            return 32'sh7fff_ffff;
        if (r < 13)
            return 32'sh0;
        if (r < 16)
            return -32'sd1;
        return $urandom;
    endfunction

    function automatic logic [63:0] pick_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 64'h0;
        if (r < 10)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] k, logic signed [31:0] id, logic [63:0] d);
        cmd_t c;
        c.kind = k;
        c.record_id = id;
        c.record_data = d;
        return c;
    endfunction

    // weighted random command; what is left after pushes and pops goes to reverse, or now and then to a spare code
    function automatic cmd_t random_cmd(int push_pct, int pop_pct);
        int r;
        logic [2:0] k;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            k = ($urandom_range(0, 1) != 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        else if (r < push_pct + pop_pct)
            k = ($urandom_range(0, 9) < 7) ? KIND_POP_FRONT : KIND_PEEK_FRONT;
        else if (r == 99)
            k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        else
            k = KIND_REVERSE;
        return make_cmd(k, pick_id(), pick_data());
    endfunction

    // one command transfer, then an optional idle gap
    task automatic send_cmd(cmd_t c);
        int gap;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        replies_due.push_back(predict_deque_op(c));
        cmds_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd <= make_cmd(KIND_PUSH_BACK, pick_id(), pick_data());
            repeat (gap) @(posedge clk);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (replies_due.size() == 0)
                report_mismatch("result with nothing expected", result.front_data, 64'h0);
            else
            begin
                want = replies_due.pop_front();
                if (result.ok !== want.ok)
                    report_mismatch("ok", 64'(result.ok), 64'(want.ok));
                if (result.front_id !== want.front_id)
                    report_mismatch("front_id", 64'(result.front_id), 64'(want.front_id));
                if (result.front_data !== want.front_data)
                    report_mismatch("front_data", result.front_data, want.front_data);
                if (result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(result.entry_count),
                                    64'(want.entry_count));
                if (result.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 64'(result.is_empty), 64'(want.is_empty));
                if (result.is_full !== want.is_full)
                    report_mismatch("is_full", 64'(result.is_full), 64'(want.is_full));
            end
            results_checked++;
        end
    end

    // reads and reverse on an empty queue, spare codes
    task automatic test_empty_queue();
        send_cmd(make_cmd(KIND_POP_FRONT, 32'sh7fff_ffff, '1));
        send_cmd(make_cmd(KIND_PEEK_FRONT, 32'sh8000_0000, 64'h0));
        send_cmd(make_cmd(KIND_REVERSE, -32'sd1, '1));
        send_cmd(make_cmd(KIND_SPARE_LO, 32'sh1234_5678, 64'hdead_beef_0bad_f00d));
        send_cmd(make_cmd(KIND_SPARE_HI, -32'sd1, '1));
    endtask

    // fill to full with field extremes, refused pushes, reverse of a full ring
    task automatic test_fill_to_full();
        send_cmd(make_cmd(KIND_PUSH_BACK, 32'sh8000_0000, 64'h0));
        send_cmd(make_cmd(KIND_PUSH_FRONT, 32'sh7fff_ffff, '1));
        send_cmd(make_cmd(KIND_PUSH_BACK, 32'sh0, 64'h8000_0000_0000_0001));
        send_cmd(make_cmd(KIND_PUSH_FRONT, -32'sd1, 64'h5555_aaaa_5555_aaaa));
        while (held < DEPTH)
            send_cmd(make_cmd(($urandom_range(0, 1) != 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                              pick_id(), pick_data()));
        send_cmd(make_cmd(KIND_PUSH_BACK, 32'sh1, 64'h1));
        send_cmd(make_cmd(KIND_PUSH_FRONT, 32'sh2, 64'h2));
        send_cmd(make_cmd(KIND_REVERSE, 32'sh0, 64'h0));
        send_cmd(make_cmd(KIND_PEEK_FRONT, 32'sh0, 64'h0));
    endtask

    // sweep the count between empty and full over and over
    task automatic test_fill_drain_waves(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            while (held < DEPTH && sent < n_items)
            begin
                send_cmd(random_cmd(80, 12));
                sent++;
            end
            repeat ($urandom_range(1, 6))
            begin
                send_cmd(random_cmd(70, 10));
                sent++;
            end
            while (held > 0 && sent < n_items)
            begin
                send_cmd(random_cmd(10, 80));
                sent++;
            end
            repeat ($urandom_range(1, 4))
            begin
                send_cmd(random_cmd(10, 70));
                sent++;
            end
        end
    endtask

    // balanced traffic around the middle of the ring
    task automatic test_mixed_traffic(int n_items);
        repeat (n_items)
            send_cmd(random_cmd(45, 40));
    endtask

    // commands back to back with no idle cycles
    task automatic test_back_to_back(int n_items);
        no_gaps = 1'b1;
        repeat (n_items / 2)
            send_cmd(random_cmd(60, 30));
        repeat (n_items - n_items / 2)
            send_cmd(random_cmd(30, 55));
        no_gaps = 1'b0;
    endtask

    // main sequence
    initial
    begin : main_seq
        int waited;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_to_full();
        test_fill_drain_waves(600);
        test_mixed_traffic(700);
        test_back_to_back(225);
        start <= 1'b0;

        // wait for every outstanding result, up to DRAIN_LIMIT, then idle before the final check
        waited = 0;
        while (replies_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (replies_due.size() != 0)
            report_mismatch("results never arrived", 64'(replies_due.size()), 64'h0);

        $display("ran %0d commands, checked %0d results", cmds_sent, results_checked);
        $display("covered %0d refused pushes on a full ring and %0d reverses",
                 refused_pushes, reverses_done);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
